// ===== hw/rtl/dct8_pkg.sv =====
`default_nettype none
package dct8_pkg;

	localparam int BLOCK_DIM_DEF = 8;
	localparam int MAX_DIM       = 16;
	localparam int ROM_IDX_W     = 4;   // per-axis index width into the cosine ROM
	localparam int COS_W         = 32;  // Q30 cosine, signed
	localparam int SAMPLE_W      = 16;
	localparam int PROD_W        = 17;  // Q1.15 cosine product, -32768..32768
	localparam int COEF_W        = 19;
	localparam int FREQ_W        = 3;
	localparam int SCALE_W       = 15;

	localparam longint unsigned Q30_ONE = 64'd1073741824;
	localparam longint unsigned PI_Q30  = 64'd3373259426;

	localparam logic signed [SCALE_W-1:0] SCALE_BOTH     = 15'sd8192;
	localparam logic signed [SCALE_W-1:0] SCALE_ONE_ZERO = 15'sd5793;
	localparam logic signed [SCALE_W-1:0] SCALE_TWO_ZERO = 15'sd4096;

	localparam logic signed [COEF_W-1:0] COEF_MAX = 19'sh3FFFF;
	localparam logic signed [COEF_W-1:0] COEF_MIN = 19'sh40000;

	typedef enum logic [1:0] {
		ENG_IDLE = 2'b01,
		ENG_RUN  = 2'b10
	} eng_state_t;

	// restoring shift-and-subtract quotient, elaboration only
	function automatic longint unsigned udiv(input longint unsigned a,
		input longint unsigned b);
		longint unsigned q;
		longint unsigned r;
		q = '0;
		r = '0;
		for (int i = 63; i >= 0; i--) begin
			r = {r[62:0], a[i]};
			if (r >= b) begin
				r    = r - b;
				q[i] = 1'b1;
			end
		end
		return q;
	endfunction

	// cos(m*pi/(2n)) in Q30, Taylor series, elaboration only
	function automatic longint cos_quadrant(input int unsigned m, input int unsigned n);
		longint unsigned th;
		longint unsigned x2;
		longint unsigned term;
		longint          sum;
		longint unsigned dv;
		th   = udiv(PI_Q30 * 64'(m) + 64'(n), 64'd2 * 64'(n));
		x2   = (th * th) >> 30;
		term = Q30_ONE;
		sum  = longint'(Q30_ONE);
		for (int i = 1; i <= 12; i++) begin
			dv   = 64'((2 * i - 1) * (2 * i));
			term = udiv((term * x2) >> 30, dv);
			if (i[0] == 1'b1) begin
				sum = sum - longint'(term);
			end else begin
				sum = sum + longint'(term);
			end
		end
		if (sum < 0) begin
			sum = 0;
		end
		if (sum > longint'(Q30_ONE)) begin
			sum = longint'(Q30_ONE);
		end
		return sum;
	endfunction

	function automatic longint cos_any(input int unsigned k_in, input int unsigned n);
		int unsigned k;
		k = k_in;
		while (k >= 4 * n) begin
			k = k - 4 * n;
		end
		if (k <= n) begin
			return cos_quadrant(k, n);
		end
		if (k <= 2 * n) begin
			return -cos_quadrant(2 * n - k, n);
		end
		if (k <= 3 * n) begin
			return -cos_quadrant(k - 2 * n, n);
		end
		return cos_quadrant(4 * n - k, n);
	endfunction

	// cosine ROM, entry (u,x) at (u*MAX_DIM + x)
	function automatic logic [MAX_DIM*MAX_DIM*COS_W-1:0] cos_rom(input int unsigned n);
		logic [MAX_DIM*MAX_DIM*COS_W-1:0] r;
		r = '0;
		for (int u = 0; u < MAX_DIM; u++) begin
			for (int x = 0; x < MAX_DIM; x++) begin
				if (u < int'(n) && x < int'(n)) begin
					r[(u * MAX_DIM + x) * COS_W +: COS_W] =
						COS_W'(cos_any(int'((2 * x + 1) * u), n));
				end
			end
		end
		return r;
	endfunction

endpackage
`default_nettype wire

// ===== hw/rtl/dct_8x8_forward_unit.sv =====
`default_nettype none
// 2-D forward DCT-II of an N x N block (N = 8 by default).
// Input: one Q8.8 sample per beat, row-major; a beat is taken at a rising
//   edge with start high and busy low.
// Output: N*N Q11.8 coefficients per block, row-major in (u,v), each on
//   coefficient/freq_row/freq_col/block_end for exactly one cycle while
//   valid is high. The receiver cannot stall; block_end marks the last.
// Storage: two sample banks. One fills from the input while the other is
//   read by the MAC engine, so a new block loads during computation.
// Compute: the engine does N^4 multiply-accumulates per block on a single
//   MAC lane, one per cycle while it runs. Each coefficient sums N*N
//   products, then passes the scale and rounding stages; the first of a
//   block appears only after the last sample of that block is taken.
// busy rises when both banks hold complete blocks and stays high until
//   the engine has issued its final read of the older bank.
// Reset (arst_n low) empties both banks, rewinds counters and drops
//   valid; sample contents are not cleared and need not be.
module dct_8x8_forward_unit #(
	parameter int BLOCK_DIM = dct8_pkg::BLOCK_DIM_DEF
) (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                start,
	output logic                                     busy,
	input  wire logic signed [dct8_pkg::SAMPLE_W-1:0] sample,
	output logic                                     valid,
	output logic signed [dct8_pkg::COEF_W-1:0]       coefficient,
	output logic [dct8_pkg::FREQ_W-1:0]              freq_row,
	output logic [dct8_pkg::FREQ_W-1:0]              freq_col,
	output logic                                     block_end
);
	localparam int SAW = $clog2(BLOCK_DIM * BLOCK_DIM);

	logic [1:0]     bank_full;
	logic           release_bank;
	logic           rd_en;
	logic           rd_bank;
	logic [SAW-1:0] rd_idx;
	logic signed [dct8_pkg::SAMPLE_W-1:0] rd_data;

	dct8_loader #(.N(BLOCK_DIM)) u_loader (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.sample       (sample),
		.busy         (busy),
		.bank_full    (bank_full),
		.release_bank (release_bank),
		.rd_en        (rd_en),
		.rd_bank      (rd_bank),
		.rd_idx       (rd_idx),
		.rd_data      (rd_data)
	);

	dct8_engine #(.N(BLOCK_DIM)) u_engine (
		.clk          (clk),
		.arst_n       (arst_n),
		.bank_full    (bank_full),
		.release_bank (release_bank),
		.rd_en        (rd_en),
		.rd_bank      (rd_bank),
		.rd_idx       (rd_idx),
		.rd_data      (rd_data),
		.valid        (valid),
		.coefficient  (coefficient),
		.freq_row     (freq_row),
		.freq_col     (freq_col),
		.block_end    (block_end)
	);

	// last beat of a block carries the top frequency pair
	a_end_freq: assert property (@(posedge clk) disable iff (!arst_n)
		valid && block_end |-> freq_row == dct8_pkg::FREQ_W'(BLOCK_DIM - 1)
			&& freq_col == dct8_pkg::FREQ_W'(BLOCK_DIM - 1))
		else $error("block_end on wrong coefficient");

	// coefficient beats are never back to back
	a_spaced: assert property (@(posedge clk) disable iff (!arst_n)
		valid |=> !valid)
		else $error("back-to-back coefficient beats");

	// a release only ever frees a bank that was full
	a_release: assert property (@(posedge clk) disable iff (!arst_n)
		release_bank |-> bank_full[rd_bank])
		else $error("release of an empty bank");

endmodule
`default_nettype wire

// ===== hw/rtl/dct8_loader.sv =====
`default_nettype none
// Front end: double-buffered sample store, fills one bank while the other is read.
module dct8_loader #(
	parameter int N = dct8_pkg::BLOCK_DIM_DEF
) (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                start,
	input  wire logic signed [dct8_pkg::SAMPLE_W-1:0] sample,
	output logic                                     busy,
	output logic [1:0]                               bank_full,
	input  wire logic                                release_bank,
	input  wire logic                                rd_en,
	input  wire logic                                rd_bank,
	input  wire logic [$clog2(N*N)-1:0]              rd_idx,
	output logic signed [dct8_pkg::SAMPLE_W-1:0]     rd_data
);
	localparam int SZ  = N * N;
	localparam int SAW = $clog2(SZ);

	logic signed [dct8_pkg::SAMPLE_W-1:0] mem [2][SZ];
	logic [SAW-1:0] wr_idx_q;
	logic           wr_bank_q;
	logic [1:0]     full_q;
	logic           accept;
	logic           blk_last;

	assign busy      = full_q[wr_bank_q];
	assign accept    = start && !busy;
	assign blk_last  = (wr_idx_q == SAW'(SZ - 1));
	assign bank_full = full_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_idx_q  <= '0;
			wr_bank_q <= 1'b0;
			full_q    <= '0;
		end else begin
			if (accept) begin
				if (blk_last) begin
					wr_idx_q  <= '0;
					wr_bank_q <= !wr_bank_q;
				end else begin
					wr_idx_q <= wr_idx_q + 1'b1;
				end
			end
			// release always targets the other bank from a completing write
			for (int b = 0; b < 2; b++) begin
				if (accept && blk_last && wr_bank_q == 1'(b)) begin
					full_q[b] <= 1'b1;
				end else if (release_bank && rd_bank == 1'(b)) begin
					full_q[b] <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			mem[wr_bank_q][wr_idx_q] <= sample;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem[rd_bank][rd_idx];
		end
	end

endmodule
`default_nettype wire

// ===== hw/rtl/dct8_engine.sv =====
`default_nettype none
// Back end: one MAC lane, N^4 products per block, coefficient finish pipeline.
module dct8_engine #(
	parameter int N = dct8_pkg::BLOCK_DIM_DEF
) (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic [1:0]                          bank_full,
	output logic                                     release_bank,
	output logic                                     rd_en,
	output logic                                     rd_bank,
	output logic [$clog2(N*N)-1:0]                   rd_idx,
	input  wire logic signed [dct8_pkg::SAMPLE_W-1:0] rd_data,
	output logic                                     valid,
	output logic signed [dct8_pkg::COEF_W-1:0]       coefficient,
	output logic [dct8_pkg::FREQ_W-1:0]              freq_row,
	output logic [dct8_pkg::FREQ_W-1:0]              freq_col,
	output logic                                     block_end
);
	localparam int SZ    = N * N;
	localparam int SAW   = $clog2(SZ);
	localparam int IW    = $clog2(N);
	localparam int RW    = dct8_pkg::ROM_IDX_W;
	localparam int CW    = dct8_pkg::COS_W;
	localparam int MUL_W = dct8_pkg::SAMPLE_W + dct8_pkg::PROD_W;
	localparam int ACC_W = MUL_W + SAW + 1;
	localparam int FIN_W = ACC_W + dct8_pkg::SCALE_W;
	localparam logic [dct8_pkg::MAX_DIM*dct8_pkg::MAX_DIM*CW-1:0] ROM = dct8_pkg::cos_rom(N);

	typedef struct packed {
		logic          vld;
		logic          first;
		logic          last;
		logic [IW-1:0] u;
		logic [IW-1:0] v;
	} tag_t;

	dct8_pkg::eng_state_t state_q;
	logic [IW-1:0]  u_q, v_q, x_q, y_q;
	logic [SAW-1:0] idx_q;
	logic           bank_q;
	logic           issue, x_end, y_end, u_end, v_end, coef_end, blk_done;

	assign issue    = (state_q == dct8_pkg::ENG_RUN);
	assign x_end    = (x_q == IW'(N - 1));
	assign y_end    = (y_q == IW'(N - 1));
	assign u_end    = (u_q == IW'(N - 1));
	assign v_end    = (v_q == IW'(N - 1));
	assign coef_end = x_end && y_end;
	assign blk_done = issue && coef_end && u_end && v_end;

	assign rd_en        = issue;
	assign rd_bank      = bank_q;
	assign rd_idx       = idx_q;
	assign release_bank = blk_done;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= dct8_pkg::ENG_IDLE;
			bank_q  <= 1'b0;
			u_q     <= '0;
			v_q     <= '0;
			x_q     <= '0;
			y_q     <= '0;
			idx_q   <= '0;
		end else begin
			unique case (state_q)
				dct8_pkg::ENG_IDLE: begin
					if (bank_full[bank_q]) begin
						state_q <= dct8_pkg::ENG_RUN;
					end
				end
				dct8_pkg::ENG_RUN: begin
					if (y_end) begin
						y_q <= '0;
						x_q <= x_end ? '0 : x_q + 1'b1;
					end else begin
						y_q <= y_q + 1'b1;
					end
					idx_q <= coef_end ? '0 : idx_q + 1'b1;
					if (coef_end) begin
						if (v_end) begin
							v_q <= '0;
							u_q <= u_end ? '0 : u_q + 1'b1;
						end else begin
							v_q <= v_q + 1'b1;
						end
					end
					if (blk_done) begin
						bank_q  <= !bank_q;
						state_q <= dct8_pkg::ENG_IDLE;
					end
				end
				default: state_q <= dct8_pkg::ENG_IDLE;
			endcase
		end
	end

	// s1: cosines and sample read
	tag_t tag_s1, tag_s2, tag_s3, tag_s4, tag_s5, tag_s6;
	logic signed [CW-1:0] cu_s1, cv_s1;
	logic signed [dct8_pkg::SAMPLE_W-1:0] smp_s2, smp_s3;
	logic signed [2*CW-1:0] cc_s2;
	logic signed [dct8_pkg::PROD_W-1:0] q_s3;
	logic signed [MUL_W-1:0] m_s4;
	logic signed [ACC_W-1:0] acc_s5;
	logic signed [FIN_W-1:0] fin_s6;

	logic [2*CW-1:0] cc_mag;
	logic [2*CW-1:0] cc_rnd;
	logic signed [dct8_pkg::PROD_W-1:0] q_next;
	logic signed [ACC_W-1:0] acc_next;
	logic signed [dct8_pkg::SCALE_W-1:0] scale;
	logic [FIN_W-1:0] fin_mag;
	logic [FIN_W-1:0] fin_rnd;
	logic signed [FIN_W-1:0] fin_r;
	logic signed [dct8_pkg::COEF_W-1:0] coef_next;

	always_comb begin
		cc_mag = cc_s2[2*CW-1] ? (2*CW)'(-cc_s2) : (2*CW)'(cc_s2);
		cc_rnd = (cc_mag + (64'd1 << 44)) >> 45;
		q_next = cc_s2[2*CW-1] ? -dct8_pkg::PROD_W'(cc_rnd) : dct8_pkg::PROD_W'(cc_rnd);
	end

	assign acc_next = tag_s4.first ? ACC_W'(m_s4) : acc_s5 + ACC_W'(m_s4);

	always_comb begin
		priority if (tag_s5.u == '0 && tag_s5.v == '0) begin
			scale = dct8_pkg::SCALE_TWO_ZERO;
		end else if (tag_s5.u == '0 || tag_s5.v == '0) begin
			scale = dct8_pkg::SCALE_ONE_ZERO;
		end else begin
			scale = dct8_pkg::SCALE_BOTH;
		end
	end

	always_comb begin
		fin_mag = fin_s6[FIN_W-1] ? FIN_W'(-fin_s6) : FIN_W'(fin_s6);
		fin_rnd = (fin_mag + (FIN_W'(1) << 29)) >> 30;
		fin_r   = fin_s6[FIN_W-1] ? -$signed(fin_rnd) : $signed(fin_rnd);
		priority if (fin_r > FIN_W'(dct8_pkg::COEF_MAX)) begin
			coef_next = dct8_pkg::COEF_MAX;
		end else if (fin_r < FIN_W'(dct8_pkg::COEF_MIN)) begin
			coef_next = dct8_pkg::COEF_MIN;
		end else begin
			coef_next = dct8_pkg::COEF_W'(fin_r);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tag_s1 <= '0;
			tag_s2 <= '0;
			tag_s3 <= '0;
			tag_s4 <= '0;
			tag_s5 <= '0;
			tag_s6 <= '0;
			valid  <= 1'b0;
		end else begin
			tag_s1 <= '{vld: issue, first: (idx_q == '0), last: coef_end, u: u_q, v: v_q};
			tag_s2 <= tag_s1;
			tag_s3 <= tag_s2;
			tag_s4 <= tag_s3;
			tag_s5 <= tag_s4;
			// s5 holds the finished sum once its last product is in
			tag_s6 <= '{vld: tag_s5.vld && tag_s5.last, first: 1'b0,
				last: tag_s5.last, u: tag_s5.u, v: tag_s5.v};
			valid  <= tag_s6.vld;
		end
	end

	always_ff @(posedge clk) begin
		cu_s1 <= ROM[{RW'(u_q), RW'(x_q)} * CW +: CW];
		cv_s1 <= ROM[{RW'(v_q), RW'(y_q)} * CW +: CW];
		cc_s2 <= cu_s1 * cv_s1;
		smp_s2 <= rd_data;
		smp_s3 <= smp_s2;
		q_s3   <= q_next;
		m_s4   <= smp_s3 * q_s3;
		if (tag_s4.vld) begin
			acc_s5 <= acc_next;
		end
		fin_s6 <= acc_s5 * scale;
		coefficient <= coef_next;
		freq_row    <= dct8_pkg::FREQ_W'(tag_s6.u);
		freq_col    <= dct8_pkg::FREQ_W'(tag_s6.v);
		block_end   <= (tag_s6.u == IW'(N - 1)) && (tag_s6.v == IW'(N - 1));
	end

endmodule
`default_nettype wire

// ===== tb/testbench.sv =====
`timescale 1ns / 100ps
// Forward 8x8 DCT unit: block-level check against an in-bench DCT predictor.
// Samples go in one beat at a time. Each full block of 64 makes the predictor
// queue 64 coefficients, which the monitor checks in (u,v) order.
module testbench;

	localparam int DIM        = 8;
	localparam int BLK        = DIM * DIM;
	localparam int STALL_MAX  = 5000;  // cycles with no beat either side
	localparam int TAIL_WAIT  = 300;   // cycles to watch for stray beats once the last block has drained
	localparam int RAND_ITEMS = 64;    // one full random block

	typedef enum int {
		PAT_ZERO,
		PAT_CONST,
		PAT_IMPULSE,
		PAT_CHECKER,
		PAT_RAMP
	} pattern_t;

	typedef struct {
		pattern_t kind;
		int       level;
		bit       dc_known;   // DC value is typed in below
		int       dc;
	} block_row_t;

	typedef struct {
		logic signed [dct8_pkg::COEF_W-1:0] coef;
		logic [dct8_pkg::FREQ_W-1:0]        row;
		logic [dct8_pkg::FREQ_W-1:0]        col;
		logic                               last;
	} coef_beat_t;

	logic                                 clk;
	logic                                 arst_n;
	logic                                 start;
	logic signed [dct8_pkg::SAMPLE_W-1:0] sample;
	wire logic                            busy;
	wire logic                            valid;
	wire logic signed [dct8_pkg::COEF_W-1:0] coefficient;
	wire logic [dct8_pkg::FREQ_W-1:0]     freq_row;
	wire logic [dct8_pkg::FREQ_W-1:0]     freq_col;
	wire logic                            block_end;

	dct_8x8_forward_unit u_dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .sample(sample),
		.valid(valid), .coefficient(coefficient), .freq_row(freq_row),
		.freq_col(freq_col), .block_end(block_end)
	);

	initial clk = 1'b0;
	always #2 clk = ~clk;

	// Outputs and start are captured mid-cycle, so each edge sees settled values.
	logic                               start_s, busy_s, valid_s, end_s;
	logic signed [dct8_pkg::COEF_W-1:0] coef_s;
	logic [dct8_pkg::FREQ_W-1:0]        row_s, col_s;
	always @(negedge clk) begin
		start_s <= start;
		busy_s  <= busy;
		valid_s <= valid;
		coef_s  <= coefficient;
		row_s   <= freq_row;
		col_s   <= freq_col;
		end_s   <= block_end;
	end

	// ---------------- predictor ----------------
	longint            cos_q30 [DIM][DIM];  // cos((2x+1)u*pi/16), Q30
	longint            basis   [DIM][DIM][DIM][DIM];  // [u][v][x][y], Q1.15
	logic signed [15:0] blk_buf [BLK];
	int                fill_cnt;
	coef_beat_t        coef_q [$];
	int                errors, beats_in, coefs_seen, blocks_done;

	// Taylor series for cos(m*pi/16), 0 <= m <= 8, in Q30
	function automatic longint quarter_cos(input int unsigned m);
		longint unsigned ang, sq, t;
		longint          acc;
		ang = (64'd3373259426 * m + DIM) / (2 * DIM);
		sq  = (ang * ang) >> 30;
		t   = 64'd1 << 30;
		acc = 64'sd1 << 30;
		for (int i = 1; i <= 12; i++) begin
			t = ((t * sq) >> 30) / longint'((2 * i - 1) * (2 * i));
			acc = (i % 2) ? acc - longint'(t) : acc + longint'(t);
		end
		if (acc < 0) acc = 0;
		if (acc > (64'sd1 << 30)) acc = 64'sd1 << 30;
		return acc;
	endfunction

	function automatic longint full_cos(input int unsigned k_in);
		int unsigned k;
		k = k_in % (4 * DIM);
		if (k <= DIM) return quarter_cos(k);
		if (k <= 2 * DIM) return -quarter_cos(2 * DIM - k);
		if (k <= 3 * DIM) return -quarter_cos(k - 2 * DIM);
		return quarter_cos(4 * DIM - k);
	endfunction

	// |p| + half, shifted, sign restored: round half away from zero
	function automatic longint round_shift(input longint p, input int sh);
		longint unsigned mag;
		longint          r;
		mag = (p < 0) ? longint'(-p) : p;
		r   = longint'((mag + (64'd1 << (sh - 1))) >> sh);
		return (p < 0) ? -r : r;
	endfunction

	task automatic build_basis();
		for (int u = 0; u < DIM; u++)
			for (int x = 0; x < DIM; x++)
				cos_q30[u][x] = full_cos((2 * x + 1) * u);
		for (int u = 0; u < DIM; u++)
			for (int v = 0; v < DIM; v++)
				for (int x = 0; x < DIM; x++)
					for (int y = 0; y < DIM; y++)
						basis[u][v][x][y] = round_shift(cos_q30[u][x] * cos_q30[v][y], 45);
	endtask

	task automatic predict_block();
		longint     acc, scale, r;
		coef_beat_t e;
		for (int u = 0; u < DIM; u++) begin
			for (int v = 0; v < DIM; v++) begin
				acc = 0;
				for (int x = 0; x < DIM; x++)
					for (int y = 0; y < DIM; y++)
						acc += longint'(blk_buf[x * DIM + y]) * basis[u][v][x][y];
				if (u == 0 && v == 0) scale = dct8_pkg::SCALE_TWO_ZERO;
				else if (u == 0 || v == 0) scale = dct8_pkg::SCALE_ONE_ZERO;
				else scale = dct8_pkg::SCALE_BOTH;
				r = round_shift(acc * scale, 30);
				if (r > 262143) r = 262143;
				if (r < -262144) r = -262144;
				e.coef = dct8_pkg::COEF_W'(r);
				e.row  = dct8_pkg::FREQ_W'(u);
				e.col  = dct8_pkg::FREQ_W'(v);
				e.last = (u == DIM - 1 && v == DIM - 1);
				coef_q.push_back(e);
			end
		end
		blocks_done++;
	endtask

	// ---------------- driver ----------------
	int idle_pct;

	task automatic send_sample(input logic signed [15:0] s);
		while ($urandom_range(99) < idle_pct) begin
			start <= 1'b0;
			@(posedge clk);
		end
		start  <= 1'b1;
		sample <= s;
		do @(posedge clk); while (busy_s);
		beats_in++;
		blk_buf[fill_cnt] = s;
		fill_cnt++;
		if (fill_cnt == BLK) begin
			fill_cnt = 0;
			predict_block();
		end
	endtask

	function automatic logic signed [15:0] pattern_sample(input block_row_t r, input int i);
		case (r.kind)
			PAT_ZERO:    return '0;
			PAT_CONST:   return 16'(r.level);
			PAT_IMPULSE: return (i == 0) ? 16'(r.level) : '0;
			PAT_CHECKER: return (((i / DIM) + (i % DIM)) % 2) ? 16'(-r.level - 1) : 16'(r.level);
			default:     return 16'(i * 1000 - 32000);
		endcase
	endfunction

	// Directed blocks: most negative constant (DC at the bottom limit) and a
	// full-scale checkerboard (top AC energy).
	block_row_t blocks [2] = '{
		'{PAT_CONST,   -32768, 1'b1, -262144},
		'{PAT_CHECKER, 32767,  1'b0, 0}
	};

	// ---------------- monitor and watchdog ----------------
	int quiet;
	always @(posedge clk) begin
		coef_beat_t e;
		if (valid_s) begin
			coefs_seen++;
			if (coef_q.size() == 0) begin
				$error("coefficient beat with nothing expected: %0d", coef_s);
				errors++;
			end else begin
				e = coef_q.pop_front();
				if (coef_s !== e.coef) begin
					$error("coefficient: expected %0d, got %0d", e.coef, coef_s);
					errors++;
				end
				if (row_s !== e.row) begin
					$error("freq_row: expected %0d, got %0d", e.row, row_s);
					errors++;
				end
				if (col_s !== e.col) begin
					$error("freq_col: expected %0d, got %0d", e.col, col_s);
					errors++;
				end
				if (end_s !== e.last) begin
					$error("block_end: expected %0d, got %0d", e.last, end_s);
					errors++;
				end
			end
		end
		if (valid_s || (start_s && !busy_s)) quiet <= 0;
		else quiet <= quiet + 1;
		if (quiet >= STALL_MAX) begin
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

	// ---------------- sequence ----------------
	initial begin
		logic signed [15:0] s;
		int                 dc_at;
		arst_n = 1'b0;
		start  = 1'b0;
		sample = '0;
		errors = 0; beats_in = 0; coefs_seen = 0; blocks_done = 0;
		fill_cnt = 0; quiet = 0;
		build_basis();
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed blocks, sender idles about a quarter of the time
		idle_pct = 24;
		foreach (blocks[b]) begin
			for (int i = 0; i < BLK; i++) send_sample(pattern_sample(blocks[b], i));
			if (blocks[b].dc_known) begin
				// DC is the first coefficient of the block just queued
				dc_at = coef_q.size() - BLK;
				if (coef_q[dc_at].coef !== dct8_pkg::COEF_W'(blocks[b].dc)) begin
					$error("coefficient: expected %0d, got %0d (predicted DC)",
						blocks[b].dc, coef_q[dc_at].coef);
					errors++;
				end
			end
		end

		// hold off until the unit has drained everything
		start <= 1'b0;
		while (coef_q.size() != 0) @(posedge clk);

		// random samples: half with heavy idling, half back-to-back
		for (int n = 0; n < RAND_ITEMS; n++) begin
			idle_pct = (n < RAND_ITEMS / 2) ? 49 : 0;
			case ($urandom_range(7))
				0:       s = 16'sh7FFF;
				1:       s = 16'sh8000;
				2:       s = 16'($urandom_range(255)) - 16'sd128;
				default: s = 16'($urandom);
			endcase
			send_sample(s);
		end
		start <= 1'b0;

		// let the last block drain, then check that nothing more appears
		while (coef_q.size() != 0) @(posedge clk);
		repeat (TAIL_WAIT) @(posedge clk);

		$display("Covered %0d sample beats in %0d full blocks, %0d coefficients checked;",
			beats_in, blocks_done, coefs_seen);
		$display("directed negative full scale and checkerboard, then random with idling.");
		if (errors == 0) begin
			$display("SCOREBOARD CLEAN");
		end else begin
			$display("SCOREBOARD MISMATCH");
		end
		$finish;
	end

endmodule

// ===== sim.f =====
hw/rtl/dct8_pkg.sv
hw/rtl/dct8_loader.sv
hw/rtl/dct8_engine.sv
hw/rtl/dct_8x8_forward_unit.sv
tb/testbench.sv
